// ----- sv/pic_pkg.sv -----
// types, constants and helpers for the packet ingress classifier
`timescale 1ns / 1ps

package pic_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned HALF_W      = 16;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned OUT_DATA_W  = 56;

	typedef enum logic [2:0] {
		VERDICT_FORWARD    = 3'd0,
		VERDICT_SRC_REJECT = 3'd1,
		VERDICT_CSUM_BAD   = 3'd2,
		VERDICT_BAD_TYPE   = 3'd3,
		VERDICT_NO_IFACE   = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_HIGH    = 2'd0,
		CLASS_MEDIUM  = 2'd1,
		CLASS_LOW     = 2'd2,
		CLASS_INVALID = 2'd3
	} prio_t;

	localparam logic [2:0] IFACE_NONE  = 3'd0;
	localparam logic [2:0] IFACE_ONE   = 3'd1;
	localparam logic [2:0] IFACE_TWO   = 3'd2;
	localparam logic [2:0] IFACE_THREE = 3'd3;
	localparam logic [2:0] IFACE_FOUR  = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ONE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TWO   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_THREE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_FOUR  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPAN       = 3'd4;

	localparam logic [WORD_W-1:0] RST_BASE_ONE   = 32'h1000_0000;
	localparam logic [WORD_W-1:0] RST_BASE_TWO   = 32'h5000_0000;
	localparam logic [WORD_W-1:0] RST_BASE_THREE = 32'h6000_0000;
	localparam logic [WORD_W-1:0] RST_BASE_FOUR  = 32'hD000_0000;
	localparam logic [WORD_W-1:0] RST_SPAN       = 32'h000F_FFFF;

	// interface intervals, both bounds exclusive
	localparam logic [WORD_W-1:0] IF1_LO = 32'hC000_0001;
	localparam logic [WORD_W-1:0] IF1_HI = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] IF2_LO = 32'h8000_0000;
	localparam logic [WORD_W-1:0] IF2_HI = 32'hC000_0000;
	localparam logic [WORD_W-1:0] IF3_LO = 32'h4000_0000;
	localparam logic [WORD_W-1:0] IF3_HI = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] IF4_LO = 32'h0000_0000;
	localparam logic [WORD_W-1:0] IF4_HI = 32'h3FFF_FFFF;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [COUNT_W-1:0] ALARM_LIMIT = 16'd15;

	// result tdata, last field in the lowest bits
	typedef struct packed {
		logic [6:0]         pad;
		logic               checksum_alarm;
		logic [7:0]         forwarded_low_byte;
		logic [COUNT_W-1:0] checksum_reject_count;
		logic [COUNT_W-1:0] source_reject_count;
		logic [2:0]         interface_id;
		prio_t              priority_class;
		verdict_t           verdict;
	} result_t;

	function automatic logic in_window(input logic [WORD_W-1:0] src,
		input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] span);
		logic [WORD_W:0] top;
		top = {1'b0, base} + {1'b0, span};
		return (src > base) && ({1'b0, src} < top);
	endfunction

	function automatic logic between(input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
	endfunction

endpackage

// ----- sv/packet_ingress_classifier.sv -----
// packet ingress classifier: checksum, source filter and interface match
`timescale 1ns / 1ps

// Takes one 32-bit packet word per cycle (source, destination, type, checksum,
// then data words; PACKET_WORDS in all) and gives one verdict per packet. Each
// request is held in an input register and processed from there when not
// stalled; the running ones-complement sum takes every word but the checksum
// word, and on the last word the sum is folded and the verdict, class,
// interface and counts go to a result register. Sustained rate is one word per
// cycle. A stalled result stalls input only when a further last word is
// waiting. Configuration writes take effect at the next clock edge.
module packet_ingress_classifier #(
	parameter int unsigned PACKET_WORDS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [pic_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  logic [pic_pkg::WORD_W-1:0]               cfg_data,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [pic_pkg::WORD_W-1:0]               s_tdata,  // packet_word
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// verdict, priority_class, interface_id, source_reject_count,
	// checksum_reject_count, forwarded_low_byte, checksum_alarm, zero fill
	output logic [pic_pkg::OUT_DATA_W-1:0]           m_tdata
);

	localparam int unsigned POS_W = $clog2(PACKET_WORDS);
	localparam int unsigned SUM_W = 17 + $clog2(PACKET_WORDS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_WORDS - 1);
	localparam logic [POS_W-1:0] POS_SRC  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_DST  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TYPE = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CSUM = POS_W'(3);

	logic [pic_pkg::WORD_W-1:0] base1_q, base2_q, base3_q, base4_q, span_q;

	logic                       valid_s1;
	logic [pic_pkg::WORD_W-1:0] word_s1;

	logic [POS_W-1:0]           pos_q;
	logic [SUM_W-1:0]           sum_q;
	logic [pic_pkg::WORD_W-1:0] src_q, dst_q, csum_q;
	pic_pkg::prio_t             type_q;
	logic [pic_pkg::COUNT_W-1:0] src_rej_q, csum_rej_q, fwd_q;

	logic                       out_valid_q;
	pic_pkg::result_t           result_q;

	logic                       is_last, fire;
	logic [16:0]                half_add;
	logic [SUM_W-1:0]           sum_next;
	logic [16:0]                fold1;
	logic [15:0]                fold2;
	logic [pic_pkg::WORD_W-1:0] csum_cur;
	logic                       csum_ok, src_rej;
	pic_pkg::prio_t             word_class;
	logic [2:0]                 iface;
	pic_pkg::verdict_t          verdict;
	logic [pic_pkg::COUNT_W-1:0] src_rej_next, csum_rej_next, fwd_next;

	assign is_last  = (pos_q == LAST_POS);
	assign fire     = valid_s1 && (!is_last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	// running sum of both half-words, checksum word counts as zero
	assign half_add = {1'b0, word_s1[15:0]} + {1'b0, word_s1[31:16]};
	assign sum_next = (pos_q == POS_CSUM) ? sum_q : sum_q + SUM_W'(half_add);
	assign fold1    = {1'b0, sum_next[15:0]} + 17'(sum_next[SUM_W-1:16]);
	assign fold2    = fold1[15:0] + 16'(fold1[16]);
	assign csum_cur = (pos_q == POS_CSUM) ? word_s1 : csum_q;
	assign csum_ok  = (csum_cur == {16'h0000, ~fold2});

	assign word_class = (word_s1 <= 32'd2) ? pic_pkg::prio_t'(word_s1[1:0])
		: pic_pkg::CLASS_INVALID;

	assign src_rej = pic_pkg::in_window(src_q, base1_q, span_q)
		|| pic_pkg::in_window(src_q, base2_q, span_q)
		|| pic_pkg::in_window(src_q, base3_q, span_q)
		|| pic_pkg::in_window(src_q, base4_q, span_q);

	always_comb begin
		iface         = pic_pkg::IFACE_NONE;
		src_rej_next  = src_rej_q;
		csum_rej_next = csum_rej_q;
		fwd_next      = fwd_q;
		if (src_rej) begin
			verdict      = pic_pkg::VERDICT_SRC_REJECT;
			src_rej_next = pic_pkg::sat_inc(src_rej_q);
		end else if (!csum_ok) begin
			verdict       = pic_pkg::VERDICT_CSUM_BAD;
			csum_rej_next = pic_pkg::sat_inc(csum_rej_q);
		end else if (type_q == pic_pkg::CLASS_INVALID) begin
			verdict = pic_pkg::VERDICT_BAD_TYPE;
		end else begin
			if (pic_pkg::between(dst_q, pic_pkg::IF1_LO, pic_pkg::IF1_HI)) begin
				iface = pic_pkg::IFACE_ONE;
			end else if (pic_pkg::between(dst_q, pic_pkg::IF2_LO, pic_pkg::IF2_HI)) begin
				iface = pic_pkg::IFACE_TWO;
			end else if (pic_pkg::between(dst_q, pic_pkg::IF3_LO, pic_pkg::IF3_HI)) begin
				iface = pic_pkg::IFACE_THREE;
			end else if (pic_pkg::between(dst_q, pic_pkg::IF4_LO, pic_pkg::IF4_HI)) begin
				iface = pic_pkg::IFACE_FOUR;
			end
			if (iface != pic_pkg::IFACE_NONE) begin
				verdict  = pic_pkg::VERDICT_FORWARD;
				fwd_next = pic_pkg::sat_inc(fwd_q);
			end else begin
				verdict = pic_pkg::VERDICT_NO_IFACE;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base1_q <= pic_pkg::RST_BASE_ONE;
			base2_q <= pic_pkg::RST_BASE_TWO;
			base3_q <= pic_pkg::RST_BASE_THREE;
			base4_q <= pic_pkg::RST_BASE_FOUR;
			span_q  <= pic_pkg::RST_SPAN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pic_pkg::CFG_BASE_ONE:   base1_q <= cfg_data;
				pic_pkg::CFG_BASE_TWO:   base2_q <= cfg_data;
				pic_pkg::CFG_BASE_THREE: base3_q <= cfg_data;
				pic_pkg::CFG_BASE_FOUR:  base4_q <= cfg_data;
				pic_pkg::CFG_SPAN:       span_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
		end
	end

	// packet state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			src_rej_q  <= '0;
			csum_rej_q <= '0;
			fwd_q      <= '0;
		end else if (fire) begin
			if (is_last) begin
				pos_q      <= '0;
				sum_q      <= '0;
				src_rej_q  <= src_rej_next;
				csum_rej_q <= csum_rej_next;
				fwd_q      <= fwd_next;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (pos_q == POS_SRC) begin
				src_q <= word_s1;
			end
			if (pos_q == POS_DST) begin
				dst_q <= word_s1;
			end
			if (pos_q == POS_TYPE) begin
				type_q <= word_class;
			end
			if (pos_q == POS_CSUM) begin
				csum_q <= word_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_last) begin
			result_q.pad                   <= '0;
			result_q.verdict               <= verdict;
			result_q.priority_class        <= type_q;
			result_q.interface_id          <= iface;
			result_q.source_reject_count   <= src_rej_next;
			result_q.checksum_reject_count <= csum_rej_next;
			result_q.forwarded_low_byte    <= fwd_next[7:0];
			result_q.checksum_alarm        <= (csum_rej_next > pic_pkg::ALARM_LIMIT);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

endmodule

// ----- sv/pic_checker.sv -----
// port-level checker for the packet ingress classifier, with its bind
`timescale 1ns / 1ps

module pic_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pic_pkg::OUT_DATA_W-1:0]   m_tdata
);

	pic_pkg::result_t res;

	assign res = m_tdata;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an interface is reported exactly when the packet is forwarded
	a_iface: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res.verdict == pic_pkg::VERDICT_FORWARD)
			== (res.interface_id != pic_pkg::IFACE_NONE)))
		else $error("interface and verdict disagree");

	// a forwarded packet has a valid type
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.verdict == pic_pkg::VERDICT_FORWARD
			|-> res.priority_class != pic_pkg::CLASS_INVALID)
		else $error("forwarded packet with invalid type");

	// alarm follows the checksum reject count
	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.checksum_alarm
			== (res.checksum_reject_count > pic_pkg::ALARM_LIMIT)))
		else $error("alarm does not match checksum reject count");

endmodule

bind packet_ingress_classifier pic_checker u_pic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/packet_ingress_classifier_test.sv -----
// testbench for the packet ingress classifier: directed packets, random packets, scoreboard
`timescale 1ns / 1ps

module packet_ingress_classifier_test;

	localparam int PKT_WORDS = 16;
	localparam int RANDOM_PHASES = 5;
	localparam int PACKETS_PER_PHASE = 16;
	localparam int SETTLE_CYCLES = 6;

	localparam logic [pic_pkg::WORD_W-1:0] IF_BOUNDS [8] = '{
		pic_pkg::IF4_LO, pic_pkg::IF4_HI, pic_pkg::IF3_LO, pic_pkg::IF3_HI,
		pic_pkg::IF2_LO, pic_pkg::IF2_HI, pic_pkg::IF1_LO, pic_pkg::IF1_HI};

	typedef enum logic [1:0] {
		CSUM_GOOD  = 2'd0,
		CSUM_FLIP  = 2'd1,
		CSUM_HIGH  = 2'd2,
		CSUM_NOISE = 2'd3
	} csum_mode_t;

	typedef enum logic [1:0] {
		FILL_ZERO   = 2'd0,
		FILL_ONES   = 2'd1,
		FILL_RANDOM = 2'd2
	} fill_mode_t;

	typedef struct packed {
		logic [pic_pkg::WORD_W-1:0] src;
		logic [pic_pkg::WORD_W-1:0] dst;
		logic [pic_pkg::WORD_W-1:0] kind;
		csum_mode_t                 csum;
		fill_mode_t                 fill;
		logic                       fixed;
		pic_pkg::verdict_t          verdict;
		logic [2:0]                 iface;
	} probe_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [pic_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [pic_pkg::WORD_W-1:0]      cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [pic_pkg::WORD_W-1:0]      s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [pic_pkg::OUT_DATA_W-1:0]  m_tdata;

	packet_ingress_classifier #(
		.PACKET_WORDS(PKT_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// classifier state as predicted
	logic [pic_pkg::WORD_W-1:0]  window_base [4];
	logic [pic_pkg::WORD_W-1:0]  window_span;
	int                          word_index;
	int unsigned                 halfword_total;
	logic [pic_pkg::WORD_W-1:0]  pkt_src;
	logic [pic_pkg::WORD_W-1:0]  pkt_dst;
	pic_pkg::prio_t              pkt_class;
	logic [pic_pkg::WORD_W-1:0]  pkt_csum;
	logic [pic_pkg::COUNT_W-1:0] src_reject_total;
	logic [pic_pkg::COUNT_W-1:0] csum_reject_total;
	logic [pic_pkg::COUNT_W-1:0] fwd_total;

	pic_pkg::result_t verdict_queue [$];
	probe_t           probes [25];
	bit               idling = 1'b0;
	int               faults = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("packet_ingress_classifier: mismatch");
		$finish;
	end

	function automatic logic [pic_pkg::HALF_W-1:0] ones_fold(input int unsigned total);
		int unsigned s;
		s = (total & 32'hFFFF) + (total >> 16);
		s = s + (s >> 16);
		return ~s[pic_pkg::HALF_W-1:0];
	endfunction

	function automatic logic [pic_pkg::COUNT_W-1:0] count_up(
		input logic [pic_pkg::COUNT_W-1:0] c);
		return (c == pic_pkg::COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic bit source_blocked(input logic [pic_pkg::WORD_W-1:0] src);
		logic [pic_pkg::WORD_W:0] top;
		bit hit = 1'b0;
		foreach (window_base[i]) begin
			top = {1'b0, window_base[i]} + {1'b0, window_span};
			if (src > window_base[i] && {1'b0, src} < top)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic [2:0] dest_interface(input logic [pic_pkg::WORD_W-1:0] dst);
		if (dst > pic_pkg::IF1_LO && dst < pic_pkg::IF1_HI)
			return pic_pkg::IFACE_ONE;
		if (dst > pic_pkg::IF2_LO && dst < pic_pkg::IF2_HI)
			return pic_pkg::IFACE_TWO;
		if (dst > pic_pkg::IF3_LO && dst < pic_pkg::IF3_HI)
			return pic_pkg::IFACE_THREE;
		if (dst > pic_pkg::IF4_LO && dst < pic_pkg::IF4_HI)
			return pic_pkg::IFACE_FOUR;
		return pic_pkg::IFACE_NONE;
	endfunction

	function automatic void reset_model();
		window_base[0] = pic_pkg::RST_BASE_ONE;
		window_base[1] = pic_pkg::RST_BASE_TWO;
		window_base[2] = pic_pkg::RST_BASE_THREE;
		window_base[3] = pic_pkg::RST_BASE_FOUR;
		window_span = pic_pkg::RST_SPAN;
		word_index = 0;
		halfword_total = 0;
		pkt_src = '0;
		pkt_dst = '0;
		pkt_class = pic_pkg::CLASS_HIGH;
		pkt_csum = '0;
		src_reject_total = '0;
		csum_reject_total = '0;
		fwd_total = '0;
	endfunction

	// one accepted packet word; the last word of a packet yields a verdict
	function automatic void absorb_word(input logic [pic_pkg::WORD_W-1:0] w);
		pic_pkg::result_t due;
		logic [2:0] iface;
		case (word_index)
			0: pkt_src = w;
			1: pkt_dst = w;
			2: pkt_class = (w <= 2) ? pic_pkg::prio_t'(w[1:0]) : pic_pkg::CLASS_INVALID;
			3: pkt_csum = w;
			default: ;
		endcase
		if (word_index != 3)
			halfword_total = halfword_total + w[15:0] + w[31:16];
		if (word_index + 1 < PKT_WORDS) begin
			word_index++;
			return;
		end
		word_index = 0;
		due = '0;
		iface = pic_pkg::IFACE_NONE;
		if (source_blocked(pkt_src)) begin
			due.verdict = pic_pkg::VERDICT_SRC_REJECT;
			src_reject_total = count_up(src_reject_total);
		end else if (pkt_csum != {16'h0, ones_fold(halfword_total)}) begin
			due.verdict = pic_pkg::VERDICT_CSUM_BAD;
			csum_reject_total = count_up(csum_reject_total);
		end else if (pkt_class == pic_pkg::CLASS_INVALID) begin
			due.verdict = pic_pkg::VERDICT_BAD_TYPE;
		end else begin
			iface = dest_interface(pkt_dst);
			if (iface != pic_pkg::IFACE_NONE) begin
				due.verdict = pic_pkg::VERDICT_FORWARD;
				fwd_total = count_up(fwd_total);
			end else begin
				due.verdict = pic_pkg::VERDICT_NO_IFACE;
			end
		end
		halfword_total = 0;
		due.priority_class = pkt_class;
		due.interface_id = iface;
		due.source_reject_count = src_reject_total;
		due.checksum_reject_count = csum_reject_total;
		due.forwarded_low_byte = fwd_total[7:0];
		due.checksum_alarm = (csum_reject_total > pic_pkg::ALARM_LIMIT);
		verdict_queue.push_back(due);
	endfunction

	task automatic compare_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			faults++;
		end
	endtask

	task automatic check_result(input pic_pkg::result_t got);
		pic_pkg::result_t want;
		if (verdict_queue.size() == 0) begin
			$display("%0t: result with none pending, actual %h", $time, got);
			faults++;
			return;
		end
		want = verdict_queue.pop_front();
		compare_field("verdict", want.verdict, got.verdict);
		compare_field("priority_class", want.priority_class, got.priority_class);
		compare_field("interface_id", want.interface_id, got.interface_id);
		compare_field("source_reject_count", want.source_reject_count,
			got.source_reject_count);
		compare_field("checksum_reject_count", want.checksum_reject_count,
			got.checksum_reject_count);
		compare_field("forwarded_low_byte", want.forwarded_low_byte, got.forwarded_low_byte);
		compare_field("checksum_alarm", want.checksum_alarm, got.checksum_alarm);
		compare_field("zero fill", want.pad, got.pad);
	endtask

	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_result(pic_pkg::result_t'(m_tdata));
			if (hold != 0)
				hold--;
			else if (idling && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 3);
			m_tready <= (hold == 0);
		end
	end

	task automatic send_word(input logic [pic_pkg::WORD_W-1:0] w);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_word(w);
	endtask

	task automatic send_packet(input logic [pic_pkg::WORD_W-1:0] src,
		input logic [pic_pkg::WORD_W-1:0] dst, input logic [pic_pkg::WORD_W-1:0] kind,
		input csum_mode_t csum, input fill_mode_t fill);
		logic [pic_pkg::WORD_W-1:0] words [PKT_WORDS];
		int unsigned acc;
		logic [pic_pkg::HALF_W-1:0] good;
		words[0] = src;
		words[1] = dst;
		words[2] = kind;
		words[3] = '0;
		for (int i = 4; i < PKT_WORDS; i++) begin
			case (fill)
				FILL_ZERO: words[i] = '0;
				FILL_ONES: words[i] = '1;
				default:   words[i] = $urandom;
			endcase
		end
		acc = 0;
		for (int i = 0; i < PKT_WORDS; i++)
			if (i != 3)
				acc = acc + words[i][15:0] + words[i][31:16];
		good = ones_fold(acc);
		case (csum)
			CSUM_GOOD: words[3] = {16'h0, good};
			CSUM_FLIP: words[3] = {16'h0, good ^ (16'h1 << $urandom_range(0, 15))};
			CSUM_HIGH: words[3] = {16'($urandom_range(1, 16'hFFFF)), good};
			default:   words[3] = $urandom;
		endcase
		for (int i = 0; i < PKT_WORDS; i++)
			send_word(words[i]);
	endtask

	task automatic write_reg(input logic [pic_pkg::CFG_INDEX_W-1:0] idx,
		input logic [pic_pkg::WORD_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_windows(input logic [pic_pkg::WORD_W-1:0] b1,
		input logic [pic_pkg::WORD_W-1:0] b2, input logic [pic_pkg::WORD_W-1:0] b3,
		input logic [pic_pkg::WORD_W-1:0] b4, input logic [pic_pkg::WORD_W-1:0] span,
		input bit spare);
		if (spare)
			for (int i = pic_pkg::CFG_SPAN + 1; i < (1 << pic_pkg::CFG_INDEX_W); i++)
				write_reg(pic_pkg::CFG_INDEX_W'(i), $urandom);
		write_reg(pic_pkg::CFG_BASE_ONE, b1);
		write_reg(pic_pkg::CFG_BASE_TWO, b2);
		write_reg(pic_pkg::CFG_BASE_THREE, b3);
		write_reg(pic_pkg::CFG_BASE_FOUR, b4);
		write_reg(pic_pkg::CFG_SPAN, span);
		cfg_wr_en <= 1'b0;
		window_base[0] = b1;
		window_base[1] = b2;
		window_base[2] = b3;
		window_base[3] = b4;
		window_span = span;
	endtask

	// sender holds off until every pending verdict is back and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [pic_pkg::WORD_W-1:0] pick_source();
		logic [pic_pkg::WORD_W-1:0] base;
		base = window_base[$urandom_range(0, 3)];
		case ($urandom_range(0, 5))
			0, 1: return base + $urandom_range(0, 3) - 1;
			2, 3: return base + window_span + $urandom_range(0, 2) - 1;
			4: return $urandom;
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	function automatic logic [pic_pkg::WORD_W-1:0] pick_dest();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return IF_BOUNDS[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
	endfunction

	function automatic logic [pic_pkg::WORD_W-1:0] pick_kind();
		case ($urandom_range(0, 9))
			0: return 32'd3;
			1: return $urandom;
			default: return $urandom_range(0, 2);
		endcase
	endfunction

	initial begin : stimulus
		probe_t row;
		pic_pkg::result_t due;
		csum_mode_t csum;
		fill_mode_t fill;
		probes = '{
			'{32'h0000_0000, 32'h0000_0001, 32'd0, CSUM_GOOD, FILL_ZERO, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_FOUR},
			'{32'h1000_0000, 32'h3FFF_FFFE, 32'd1, CSUM_GOOD, FILL_ONES, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_FOUR},
			'{32'h1000_0001, 32'h0000_0001, 32'd0, CSUM_GOOD, FILL_ZERO, 1'b1,
				pic_pkg::VERDICT_SRC_REJECT, pic_pkg::IFACE_NONE},
			'{32'h100F_FFFE, 32'h0000_0001, 32'd2, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_SRC_REJECT, pic_pkg::IFACE_NONE},
			'{32'h100F_FFFF, 32'h0000_0001, 32'd2, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_FOUR},
			'{32'hD000_0005, 32'h0000_0001, 32'd0, CSUM_FLIP, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_SRC_REJECT, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h0000_0001, 32'd0, CSUM_FLIP, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_CSUM_BAD, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h0000_0001, 32'd0, CSUM_HIGH, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_CSUM_BAD, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, CSUM_FLIP, FILL_ZERO, 1'b1,
				pic_pkg::VERDICT_CSUM_BAD, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h0000_0001, 32'd3, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_BAD_TYPE, pic_pkg::IFACE_NONE},
			'{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, CSUM_GOOD, FILL_ONES, 1'b1,
				pic_pkg::VERDICT_BAD_TYPE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h0000_0000, 32'd0, CSUM_GOOD, FILL_ZERO, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h3FFF_FFFF, 32'd1, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h4000_0000, 32'd2, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h4000_0001, 32'd0, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_THREE},
			'{32'h0000_0000, 32'h7FFF_FFFF, 32'd1, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h8000_0000, 32'd2, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'h8000_0001, 32'd0, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_TWO},
			'{32'h0000_0000, 32'hBFFF_FFFF, 32'd1, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_TWO},
			'{32'h0000_0000, 32'hC000_0000, 32'd2, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'hC000_0001, 32'd0, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h0000_0000, 32'hC000_0002, 32'd1, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_ONE},
			'{32'h0000_0000, 32'hFFFF_FFFE, 32'd2, CSUM_GOOD, FILL_ONES, 1'b1,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_ONE},
			'{32'h0000_0000, 32'hFFFF_FFFF, 32'd0, CSUM_GOOD, FILL_RANDOM, 1'b1,
				pic_pkg::VERDICT_NO_IFACE, pic_pkg::IFACE_NONE},
			'{32'h1234_5678, 32'h9ABC_DEF0, 32'd1, CSUM_GOOD, FILL_RANDOM, 1'b0,
				pic_pkg::VERDICT_FORWARD, pic_pkg::IFACE_NONE}
		};
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idling = 1'b1;
		foreach (probes[i]) begin
			row = probes[i];
			send_packet(row.src, row.dst, row.kind, row.csum, row.fill);
			if (row.fixed) begin
				due = verdict_queue.pop_back();
				due.verdict = row.verdict;
				due.interface_id = row.iface;
				verdict_queue.push_back(due);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case (phase)
				0: program_windows($urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 32'hFFFF), 1'b1);
				1: program_windows('0, '0, '0, '0, '0, 1'b0);
				2: program_windows(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hF000_0000,
					32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
				3: program_windows($urandom, $urandom, $urandom, $urandom,
					$urandom >> $urandom_range(0, 31), 1'b0);
				default: program_windows(pic_pkg::RST_BASE_ONE, pic_pkg::RST_BASE_TWO,
					pic_pkg::RST_BASE_THREE, pic_pkg::RST_BASE_FOUR, pic_pkg::RST_SPAN,
					1'b0);
			endcase
			for (int n = 0; n < PACKETS_PER_PHASE; n++) begin
				idling = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 15) == 0) begin
					send_packet($urandom, $urandom, $urandom, CSUM_NOISE, FILL_RANDOM);
				end else begin
					case ($urandom_range(0, 7))
						0: csum = CSUM_FLIP;
						1: csum = CSUM_HIGH;
						default: csum = CSUM_GOOD;
					endcase
					case ($urandom_range(0, 7))
						0: fill = FILL_ZERO;
						1: fill = FILL_ONES;
						default: fill = FILL_RANDOM;
					endcase
					send_packet(pick_source(), pick_dest(), pick_kind(), csum, fill);
				end
			end
		end

		settle();
		if (faults == 0)
			$display("packet_ingress_classifier: match");
		else
			$display("packet_ingress_classifier: mismatch");
		$finish;
	end

endmodule
